[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies a consequence on the same clock edge.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check that a condition implies a consequence at the following clock edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/tbac_pkg.sv]
// ----------------------------------------------------------------------------
// tbac_pkg
// Types and constants of the twelve-bit accumulator processor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package tbac_pkg;
    localparam int WORD_W = 12;
    localparam logic [11:0] START_PC    = 12'o0200;
    localparam logic [11:0] OFFSET_MASK = 12'o0177;
    localparam logic [11:0] PAGE_MASK   = 12'o7600;
    localparam logic [11:0] AUTO_LO     = 12'o0010;
    localparam logic [11:0] AUTO_HI     = 12'o0017;
    localparam logic [11:0] IOT_PRINT   = 12'o6046;

    typedef enum logic [2:0] {
        OP_AND = 3'd0,
        OP_TAD = 3'd1,
        OP_ISZ = 3'd2,
        OP_DCA = 3'd3,
        OP_JMS = 3'd4,
        OP_JMP = 3'd5,
        OP_IOT = 3'd6,
        OP_OPR = 3'd7
    } opcode_t;

    typedef struct packed {
        logic [11:0] ac;
        logic        link;
    } acl_t;

    function automatic acl_t group_one(logic [11:0] ins, logic [11:0] ac_in, logic l_in);
        logic [11:0] ac;
        logic        l;
        logic        t;
        acl_t        r;
        ac = ac_in;
        l  = l_in;
        if (ins[7]) ac = '0;
        if (ins[6]) l = 1'b0;
        if (ins[5]) ac = ~ac;
        if (ins[4]) l = ~l;
        if (ins[0]) begin
            ac = ac + 12'd1;
            if (ac == '0) l = ~l;
        end
        if (ins[3]) begin
            t = ac[0]; ac = {l, ac[11:1]}; l = t;
            if (ins[1]) begin
                t = ac[0]; ac = {l, ac[11:1]}; l = t;
            end
        end else if (ins[2]) begin
            t = ac[11]; ac = {ac[10:0], l}; l = t;
            if (ins[1]) begin
                t = ac[11]; ac = {ac[10:0], l}; l = t;
            end
        end else if (ins[1]) begin
            ac = {ac[5:0], ac[11:6]};
        end
        r.ac   = ac;
        r.link = l;
        return r;
    endfunction
endpackage
`default_nettype wire

[rtl/twelve_bit_accumulator_cpu.sv]
// ----------------------------------------------------------------------------
// twelve_bit_accumulator_cpu
// Twelve-bit accumulator processor with a 4096-word single-port memory.
// ----------------------------------------------------------------------------
// After reset a clearing pass zeroes the memory, one word a cycle, before
// the first transaction is taken. A transaction is taken only while the
// processor is idle and no result is waiting. A load, or a step while
// halted, goes straight to the done state. A step otherwise fetches and
// decodes; an operate or IOT instruction then finishes, while a memory
// reference instruction passes through an indirect state if indirect, with
// or without auto-increment, then an operand state, an execute state for
// AND, TAD and ISZ, and for ISZ a write-back state. Every memory access
// goes through the one memory port with a registered read. The result is
// held until taken, and the next transaction can be accepted after that.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module twelve_bit_accumulator_cpu
    import tbac_pkg::*;
#(
    parameter int MEM_WORDS = 4096
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        op,
    input  wire logic [11:0] address,
    input  wire logic [11:0] data_word,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [11:0]      prog_counter,
    output logic [11:0]      accum,
    output logic             link_bit,
    output logic             is_halted,
    output logic             char_valid,
    output logic [7:0]       char_out,
    output logic [31:0]      instr_count
);
    localparam int AW = $clog2(MEM_WORDS);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_FETCH, S_DECODE, S_IND, S_AUTO, S_OPRD, S_EXEC,
        S_ISZ, S_DONE
    } state_t;

    state_t      state_reg;
    logic [AW:0] clr_reg;
    logic [11:0] pc_reg, ac_reg, ins_reg, ea_reg, here_reg;
    logic        link_reg, halt_reg, printed_reg;
    logic [7:0]  ch_reg;
    logic [31:0] cnt_reg;

    logic [11:0] mem [MEM_WORDS];
    logic [11:0] rdata;
    logic        we;
    logic [AW-1:0] maddr;
    logic [11:0] wdata;
    logic        re;

    always_ff @(posedge clk)
    begin
        if (we) mem[maddr] <= wdata;
        if (re) rdata <= mem[maddr];
    end

    logic [11:0] ea0;
    acl_t        g1;
    logic        hit;
    logic [11:0] inc;
    opcode_t     opc;
    assign ea0 = (ins_reg & OFFSET_MASK) | (ins_reg[7] ? (here_reg & PAGE_MASK) : 12'd0);
    assign g1  = group_one(ins_reg, ac_reg, link_reg);
    assign inc = rdata + 12'd1;
    assign opc = opcode_t'(ins_reg[11:9]);
    always_comb
    begin
        hit = (ins_reg[6] && ac_reg[11]) || (ins_reg[5] && ac_reg == '0) ||
              (ins_reg[4] && link_reg);
        if (ins_reg[3]) hit = !hit;
    end

    assign in_ready = (state_reg == S_IDLE) && !out_valid;

    always_comb
    begin
        we = 1'b0; re = 1'b0; maddr = ea_reg[AW-1:0]; wdata = ac_reg;
        case (state_reg)
            S_CLEAR:
            begin
                we = 1'b1; maddr = clr_reg[AW-1:0]; wdata = '0;
            end
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    if (!op)
                    begin
                        we = 1'b1; maddr = address[AW-1:0]; wdata = data_word;
                    end
                    else
                    begin
                        re = 1'b1; maddr = pc_reg[AW-1:0];
                    end
                end
            end
            S_DECODE:
            begin
                maddr = ea0[AW-1:0];
                re = (opc != OP_IOT) && (opc != OP_OPR) && ins_reg[8];
            end
            S_IND:
            begin
                maddr = ea_reg[AW-1:0];
                if (ea_reg inside {[AUTO_LO:AUTO_HI]})
                begin
                    we = 1'b1; wdata = inc;
                end
                else
                begin
                    re = 1'b1; maddr = rdata[AW-1:0];
                end
            end
            S_AUTO:
            begin
                re = 1'b1;
            end
            S_OPRD:
            begin
                maddr = ea_reg[AW-1:0];
                case (opc)
                    OP_AND, OP_TAD, OP_ISZ: re = 1'b1;
                    OP_DCA:
                    begin
                        we = 1'b1; wdata = ac_reg;
                    end
                    OP_JMS:
                    begin
                        we = 1'b1; wdata = pc_reg;
                    end
                    default: ;
                endcase
            end
            S_ISZ:
            begin
                we = 1'b1; wdata = inc;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            pc_reg      <= START_PC;
            ac_reg      <= '0;
            link_reg    <= 1'b0;
            halt_reg    <= 1'b0;
            cnt_reg     <= '0;
            printed_reg <= 1'b0;
            ch_reg      <= '0;
            out_valid   <= 1'b0;
            ins_reg     <= '0;
            ea_reg      <= '0;
            here_reg    <= '0;
        end
        else
        begin
            if (out_valid && out_ready) out_valid <= 1'b0;
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == (AW+1)'(MEM_WORDS - 1)) state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        printed_reg <= 1'b0;
                        ch_reg      <= '0;
                        if (!op || halt_reg)
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            here_reg  <= pc_reg;
                            pc_reg    <= pc_reg + 12'd1;
                            cnt_reg   <= cnt_reg + 32'd1;
                            state_reg <= S_FETCH;
                        end
                    end
                end
                S_FETCH:
                begin
                    ins_reg   <= rdata;
                    state_reg <= S_DECODE;
                end
                S_DECODE:
                begin
                    ea_reg <= ea0;
                    case (opc)
                        OP_IOT:
                        begin
                            if (ins_reg == IOT_PRINT)
                            begin
                                printed_reg <= 1'b1;
                                ch_reg      <= ac_reg[7:0];
                            end
                            state_reg <= S_DONE;
                        end
                        OP_OPR:
                        begin
                            if (!ins_reg[8])
                            begin
                                ac_reg   <= g1.ac;
                                link_reg <= g1.link;
                            end
                            else if (!ins_reg[0])
                            begin
                                if (hit) pc_reg <= pc_reg + 12'd1;
                                if (ins_reg[7]) ac_reg <= '0;
                                if (ins_reg[1]) halt_reg <= 1'b1;
                            end
                            state_reg <= S_DONE;
                        end
                        default: state_reg <= ins_reg[8] ? S_IND : S_OPRD;
                    endcase
                end
                S_IND:
                begin
                    if (ea_reg inside {[AUTO_LO:AUTO_HI]})
                    begin
                        ea_reg    <= inc;
                        state_reg <= S_OPRD;
                        if (opc == OP_JMP || opc == OP_JMS || opc == OP_DCA)
                        begin
                            state_reg <= S_OPRD;
                        end
                    end
                    else
                    begin
                        ea_reg    <= rdata;
                        state_reg <= S_OPRD;
                    end
                end
                S_OPRD:
                begin
                    case (opc)
                        OP_AND, OP_TAD, OP_ISZ: state_reg <= S_EXEC;
                        OP_DCA:
                        begin
                            ac_reg    <= '0;
                            state_reg <= S_DONE;
                        end
                        OP_JMS:
                        begin
                            pc_reg    <= ea_reg + 12'd1;
                            state_reg <= S_DONE;
                        end
                        default:
                        begin
                            pc_reg <= ea_reg;
                            if (ea_reg == here_reg) halt_reg <= 1'b1;
                            state_reg <= S_DONE;
                        end
                    endcase
                end
                S_EXEC:
                begin
                    case (opc)
                        OP_AND:
                        begin
                            ac_reg    <= ac_reg & rdata;
                            state_reg <= S_DONE;
                        end
                        OP_TAD:
                        begin
                            {link_reg, ac_reg} <= {link_reg ^ (({1'b0, ac_reg} +
                                {1'b0, rdata}) > 13'h0FFF), ac_reg + rdata};
                            state_reg <= S_DONE;
                        end
                        default: state_reg <= S_ISZ;
                    endcase
                end
                S_ISZ:
                begin
                    if (inc == '0) pc_reg <= pc_reg + 12'd1;
                    state_reg <= S_DONE;
                end
                S_AUTO: state_reg <= S_OPRD;
                S_DONE:
                begin
                    out_valid <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign prog_counter = pc_reg;
    assign accum        = ac_reg;
    assign link_bit     = link_reg;
    assign is_halted    = halt_reg;
    assign char_valid   = printed_reg;
    assign char_out     = ch_reg;
    assign instr_count  = cnt_reg;

    `ASSERT_IMPLY(a_no_take_busy, clk, rst_n, state_reg != S_IDLE, !in_ready)
    `ASSERT_NEXT(a_halt_sticky, clk, rst_n, halt_reg, halt_reg)
    `ASSERT_IMPLY(a_char_zero, clk, rst_n, out_valid && !printed_reg, ch_reg == '0)
endmodule
`default_nettype wire
